// File: hdl/bafn_pkg.sv
// ----------------------------------------------------------------------------
// Bearing angle package
// Shared widths, turn constants, the CORDIC stage angle table and the
// control word that travels down the pipeline with each request.
// ----------------------------------------------------------------------------
package bafn_pkg;

	localparam int ANGLE_BITS_DEF    = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int MAX_STAGES        = 32;

	localparam int COORD_W   = 32;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int TOL_W     = 16;
	localparam int BEARING_W = 16;
	localparam int PRESHIFT  = 24;
	localparam int XY_W      = 60;
	localparam int Z_W       = 32;
	localparam int T_W       = 33;

	localparam logic [T_W-1:0] TURN_ZERO          = 33'h0_0000_0000;
	localparam logic [T_W-1:0] TURN_QUARTER       = 33'h0_4000_0000;
	localparam logic [T_W-1:0] TURN_HALF          = 33'h0_8000_0000;
	localparam logic [T_W-1:0] TURN_THREE_QUARTER = 33'h0_C000_0000;
	localparam logic [T_W-1:0] TURN_FULL          = 33'h1_0000_0000;

	typedef struct packed {
		logic           valid;
		logic           special;
		logic           dx_neg;
		logic           dy_neg;
		logic [T_W-1:0] spec_turn;
	} ctl_t;

	function automatic logic [Z_W-1:0] stage_angle(input int unsigned idx);
		logic [Z_W-1:0] a;
		case (idx)
			0:       a = 32'h20000000;
			1:       a = 32'h12E4051E;
			2:       a = 32'h09FB385B;
			3:       a = 32'h051111D4;
			4:       a = 32'h028B0D43;
			5:       a = 32'h0145D7E1;
			6:       a = 32'h00A2F61E;
			7:       a = 32'h00517C55;
			8:       a = 32'h0028BE53;
			9:       a = 32'h00145F2F;
			10:      a = 32'h000A2F98;
			11:      a = 32'h000517CC;
			12:      a = 32'h00028BE6;
			13:      a = 32'h000145F3;
			14:      a = 32'h0000A2FA;
			15:      a = 32'h0000517D;
			16:      a = 32'h000028BE;
			17:      a = 32'h0000145F;
			18:      a = 32'h00000A30;
			19:      a = 32'h00000518;
			20:      a = 32'h0000028C;
			21:      a = 32'h00000146;
			22:      a = 32'h000000A3;
			23:      a = 32'h00000051;
			24:      a = 32'h00000029;
			25:      a = 32'h00000014;
			26:      a = 32'h0000000A;
			27:      a = 32'h00000005;
			28:      a = 32'h00000003;
			29:      a = 32'h00000001;
			30:      a = 32'h00000001;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

endpackage

// File: hdl/bearing_angle_full_turn.sv
// ----------------------------------------------------------------------------
// Bearing angle, full turn
// Bearing from observer to target as an unsigned fraction of a full turn,
// found by a pipelined vectoring CORDIC with near-axis handling.
//
//   Channel   Handshake          Payload
//   request   start / busy       observer_x, observer_y, target_x, target_y
//   result    done (one cycle)   bearing
//   config    cfg_wr_en          cfg_wr_data (zero tolerance)
//
// A request is taken in every cycle; busy is never raised.
// The pipeline has three front stages, one per CORDIC stage and two for
// quadrant mapping and rounding.
// Reset clears the valid bits and sets the tolerance to zero.
// The result cannot be held off, so nothing in the pipeline ever stalls.
// ----------------------------------------------------------------------------
module bearing_angle_full_turn #(
	parameter int ANGLE_BITS    = bafn_pkg::ANGLE_BITS_DEF,
	parameter int CORDIC_STAGES = bafn_pkg::CORDIC_STAGES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [bafn_pkg::COORD_W-1:0]      observer_x,
	input  logic [bafn_pkg::COORD_W-1:0]      observer_y,
	input  logic [bafn_pkg::COORD_W-1:0]      target_x,
	input  logic [bafn_pkg::COORD_W-1:0]      target_y,
	input  logic                              cfg_wr_en,
	input  logic [bafn_pkg::TOL_W-1:0]        cfg_wr_data,
	output logic                              done,
	output logic [bafn_pkg::BEARING_W-1:0]    bearing
);

	localparam int NSTG = (CORDIC_STAGES > bafn_pkg::MAX_STAGES)
		? bafn_pkg::MAX_STAGES : CORDIC_STAGES;

	logic [bafn_pkg::TOL_W-1:0]       tolerance_q;
	logic signed [bafn_pkg::XY_W-1:0] x_chain [NSTG+1];
	logic signed [bafn_pkg::XY_W-1:0] y_chain [NSTG+1];
	logic signed [bafn_pkg::Z_W-1:0]  z_chain [NSTG+1];
	bafn_pkg::ctl_t                   ctl_chain [NSTG+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= '0;
		end else if (cfg_wr_en) begin
			tolerance_q <= cfg_wr_data;
		end
	end

	assign busy       = 1'b0;
	assign z_chain[0] = '0;

	bafn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.observer_x (observer_x),
		.observer_y (observer_y),
		.target_x   (target_x),
		.target_y   (target_y),
		.tolerance  (tolerance_q),
		.x_init     (x_chain[0]),
		.y_init     (y_chain[0]),
		.ctl_out    (ctl_chain[0])
	);

	generate
		for (genvar g = 0; g < NSTG; g++) begin : g_stage
			bafn_stage #(
				.STAGE (g)
			) u_stage (
				.clk     (clk),
				.arst_n  (arst_n),
				.x_in    (x_chain[g]),
				.y_in    (y_chain[g]),
				.z_in    (z_chain[g]),
				.ctl_in  (ctl_chain[g]),
				.x_out   (x_chain[g+1]),
				.y_out   (y_chain[g+1]),
				.z_out   (z_chain[g+1]),
				.ctl_out (ctl_chain[g+1])
			);
		end
	endgenerate

	bafn_back #(
		.ANGLE_BITS (ANGLE_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.z_in    (z_chain[NSTG]),
		.ctl_in  (ctl_chain[NSTG]),
		.done    (done),
		.bearing (bearing)
	);

endmodule

// File: hdl/bafn_front.sv
// ----------------------------------------------------------------------------
// Bearing angle front end
// Forms the coordinate differences, their magnitudes and signs, detects the
// near-axis cases against the tolerance and loads the CORDIC start vector.
// ----------------------------------------------------------------------------
module bafn_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [bafn_pkg::COORD_W-1:0]      observer_x,
	input  logic [bafn_pkg::COORD_W-1:0]      observer_y,
	input  logic [bafn_pkg::COORD_W-1:0]      target_x,
	input  logic [bafn_pkg::COORD_W-1:0]      target_y,
	input  logic [bafn_pkg::TOL_W-1:0]        tolerance,
	output logic signed [bafn_pkg::XY_W-1:0]  x_init,
	output logic signed [bafn_pkg::XY_W-1:0]  y_init,
	output bafn_pkg::ctl_t                    ctl_out
);

	localparam int DW = bafn_pkg::DIFF_W;

	logic                 valid_s1;
	logic [DW-1:0]        dx_s1;
	logic [DW-1:0]        dy_s1;
	logic                 valid_s2;
	logic [DW-1:0]        ax_s2;
	logic [DW-1:0]        ay_s2;
	logic                 dx_neg_s2;
	logic                 dy_neg_s2;
	logic                 dx_pos_s2;
	logic                 dy_pos_s2;
	logic [DW-1:0]        ax_c;
	logic [DW-1:0]        ay_c;
	logic [DW-1:0]        tol_ext;
	bafn_pkg::ctl_t       ctl_c;
	bafn_pkg::ctl_t       ctl_s3;
	logic signed [bafn_pkg::XY_W-1:0] x_s3;
	logic signed [bafn_pkg::XY_W-1:0] y_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= {target_x[bafn_pkg::COORD_W-1], target_x}
			- {observer_x[bafn_pkg::COORD_W-1], observer_x};
		dy_s1 <= {target_y[bafn_pkg::COORD_W-1], target_y}
			- {observer_y[bafn_pkg::COORD_W-1], observer_y};
	end

	always_comb begin
		ax_c = dx_s1[DW-1] ? (~dx_s1 + DW'(1)) : dx_s1;
		ay_c = dy_s1[DW-1] ? (~dy_s1 + DW'(1)) : dy_s1;
	end

	always_ff @(posedge clk) begin
		ax_s2     <= ax_c;
		ay_s2     <= ay_c;
		dx_neg_s2 <= dx_s1[DW-1];
		dy_neg_s2 <= dy_s1[DW-1];
		dx_pos_s2 <= !dx_s1[DW-1] && (|dx_s1);
		dy_pos_s2 <= !dy_s1[DW-1] && (|dy_s1);
	end

	always_comb begin
		tol_ext         = DW'(tolerance);
		ctl_c.valid     = valid_s2;
		ctl_c.dx_neg    = dx_neg_s2;
		ctl_c.dy_neg    = dy_neg_s2;
		ctl_c.special   = 1'b0;
		ctl_c.spec_turn = bafn_pkg::TURN_ZERO;
		if (ax_s2 <= tol_ext) begin
			ctl_c.special   = 1'b1;
			ctl_c.spec_turn = dy_pos_s2 ? bafn_pkg::TURN_QUARTER
				: bafn_pkg::TURN_THREE_QUARTER;
		end else if (ay_s2 <= tol_ext) begin
			ctl_c.special   = 1'b1;
			ctl_c.spec_turn = dx_pos_s2 ? bafn_pkg::TURN_ZERO : bafn_pkg::TURN_HALF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3 <= ctl_c;
		end
	end

	always_ff @(posedge clk) begin
		x_s3 <= $signed(bafn_pkg::XY_W'(ax_s2) << bafn_pkg::PRESHIFT);
		y_s3 <= $signed(bafn_pkg::XY_W'(ay_s2) << bafn_pkg::PRESHIFT);
	end

	assign x_init  = x_s3;
	assign y_init  = y_s3;
	assign ctl_out = ctl_s3;

endmodule

// File: hdl/bafn_stage.sv
// ----------------------------------------------------------------------------
// Bearing angle CORDIC stage
// One registered vectoring rotation: drives y towards zero and accumulates
// the rotation angle of this stage.
// ----------------------------------------------------------------------------
module bafn_stage #(
	parameter int STAGE = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic signed [bafn_pkg::XY_W-1:0]  x_in,
	input  logic signed [bafn_pkg::XY_W-1:0]  y_in,
	input  logic signed [bafn_pkg::Z_W-1:0]   z_in,
	input  bafn_pkg::ctl_t                    ctl_in,
	output logic signed [bafn_pkg::XY_W-1:0]  x_out,
	output logic signed [bafn_pkg::XY_W-1:0]  y_out,
	output logic signed [bafn_pkg::Z_W-1:0]   z_out,
	output bafn_pkg::ctl_t                    ctl_out
);

	localparam logic signed [bafn_pkg::Z_W-1:0] ANGLE =
		$signed(bafn_pkg::stage_angle(STAGE));

	logic signed [bafn_pkg::XY_W-1:0] xs;
	logic signed [bafn_pkg::XY_W-1:0] ys;
	logic                             y_pos;
	logic signed [bafn_pkg::XY_W-1:0] x_s1;
	logic signed [bafn_pkg::XY_W-1:0] y_s1;
	logic signed [bafn_pkg::Z_W-1:0]  z_s1;
	bafn_pkg::ctl_t                   ctl_s1;

	always_comb begin
		xs    = x_in >>> STAGE;
		ys    = y_in >>> STAGE;
		y_pos = !y_in[bafn_pkg::XY_W-1] && (|y_in);
	end

	always_ff @(posedge clk) begin
		if (y_pos) begin
			x_s1 <= x_in + ys;
			y_s1 <= y_in - xs;
			z_s1 <= z_in + ANGLE;
		end else begin
			x_s1 <= x_in - ys;
			y_s1 <= y_in + xs;
			z_s1 <= z_in - ANGLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
		end
	end

	assign x_out   = x_s1;
	assign y_out   = y_s1;
	assign z_out   = z_s1;
	assign ctl_out = ctl_s1;

endmodule

// File: hdl/bafn_back.sv
// ----------------------------------------------------------------------------
// Bearing angle back end
// Clamps the first-quadrant angle, maps it to its quadrant or takes the
// near-axis answer, then rounds the turn fraction to the output precision.
// ----------------------------------------------------------------------------
module bafn_back #(
	parameter int ANGLE_BITS = bafn_pkg::ANGLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [bafn_pkg::Z_W-1:0]     z_in,
	input  bafn_pkg::ctl_t                      ctl_in,
	output logic                                done,
	output logic [bafn_pkg::BEARING_W-1:0]      bearing
);

	localparam int TW = bafn_pkg::T_W;
	localparam int RW = TW + 1;

	logic [TW-1:0]                   a_c;
	logic [TW-1:0]                   t_c;
	logic [TW-1:0]                   t_s1;
	logic                            valid_s1;
	logic [RW-1:0]                   rnd_c;
	logic [bafn_pkg::BEARING_W-1:0]  bearing_c;
	logic [bafn_pkg::BEARING_W-1:0]  bearing_s2;
	logic                            valid_s2;

	always_comb begin
		if (z_in[bafn_pkg::Z_W-1]) begin
			a_c = bafn_pkg::TURN_ZERO;
		end else if (TW'(z_in) > bafn_pkg::TURN_QUARTER) begin
			a_c = bafn_pkg::TURN_QUARTER;
		end else begin
			a_c = TW'(z_in);
		end
		if (ctl_in.special) begin
			t_c = ctl_in.spec_turn;
		end else if (ctl_in.dx_neg) begin
			t_c = ctl_in.dy_neg ? (bafn_pkg::TURN_HALF + a_c) : (bafn_pkg::TURN_HALF - a_c);
		end else begin
			t_c = ctl_in.dy_neg ? (bafn_pkg::TURN_FULL - a_c) : a_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= ctl_in.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		t_s1 <= t_c;
	end

	generate
		if (ANGLE_BITS >= 32) begin : g_no_round
			assign rnd_c = RW'(t_s1[31:0]);
		end else begin : g_round
			localparam int DROP = 32 - ANGLE_BITS;
			localparam logic [RW-1:0] HALF_LSB = RW'(1) << (DROP - 1);
			assign rnd_c = (RW'(t_s1) + HALF_LSB) >> DROP;
		end
	endgenerate

	always_comb begin
		for (int i = 0; i < bafn_pkg::BEARING_W; i++) begin
			bearing_c[i] = (i < ANGLE_BITS) ? rnd_c[i] : 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		bearing_s2 <= bearing_c;
	end

	assign done    = valid_s2;
	assign bearing = bearing_s2;

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Bearing angle testbench
// Drives position requests into the bearing block at random rates and
// checks each bearing against its directed row's value or a cycle-free
// predictor of the CORDIC. It starts with a table of directed rows and
// then moves on to random phases, each under its own zero tolerance.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          N_STAGES  = bafn_pkg::CORDIC_STAGES_DEF;
	localparam int          LAT       = bafn_pkg::CORDIC_STAGES_DEF + 5;
	localparam int unsigned LIMIT     = 400000;
	localparam int          N_PHASES  = 8;
	localparam int          PHASE_LEN = 140;
	localparam logic [31:0] C_MIN     = 32'h8000_0000;
	localparam logic [31:0] C_MAX     = 32'h7FFF_FFFF;

	localparam longint ARC_TAB [0:31] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
		64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
		64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
		64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
		64'h00000001, 64'h00000000
	};

	typedef struct packed {
		logic [31:0]                    ox;
		logic [31:0]                    oy;
		logic [31:0]                    tx;
		logic [31:0]                    ty;
		logic [bafn_pkg::TOL_W-1:0]     tol;
		logic                           typed;
		logic [bafn_pkg::BEARING_W-1:0] want;
	} dir_row_t;

	localparam int N_DIR = 25;
	localparam dir_row_t DIR_TAB [N_DIR] = '{
		'{0, 0, 0, 0, 16'h0000, 1'b1, 16'hC000},
		'{0, 0, 0, 1, 16'h0000, 1'b1, 16'h4000},
		'{0, 0, 1, 0, 16'h0000, 1'b1, 16'h0000},
		'{0, 0, -1, 0, 16'h0000, 1'b1, 16'h8000},
		'{0, 0, 0, -1, 16'h0000, 1'b1, 16'hC000},
		'{C_MIN, 0, C_MAX, 0, 16'h0000, 1'b1, 16'h0000},
		'{C_MAX, 0, C_MIN, 0, 16'h0000, 1'b1, 16'h8000},
		'{5, C_MIN, 5, C_MAX, 16'h0000, 1'b1, 16'h4000},
		'{5, C_MAX, 5, C_MIN, 16'h0000, 1'b1, 16'hC000},
		'{C_MIN, C_MIN, C_MIN, C_MIN, 16'h0000, 1'b1, 16'hC000},
		'{C_MAX, C_MAX, C_MAX, C_MAX, 16'h0000, 1'b1, 16'hC000},
		'{0, 0, 1, 1, 16'h0000, 1'b0, 16'h0000},
		'{C_MIN, C_MIN, C_MAX, C_MAX, 16'h0000, 1'b0, 16'h0000},
		'{C_MAX, C_MAX, C_MIN, C_MIN, 16'h0000, 1'b0, 16'h0000},
		'{C_MAX, C_MIN, C_MIN, C_MAX, 16'h0000, 1'b0, 16'h0000},
		'{C_MIN, C_MAX, C_MAX, C_MIN, 16'h0000, 1'b0, 16'h0000},
		'{0, 0, 3, -1, 16'h0000, 1'b0, 16'h0000},
		'{100, 200, -7, 201, 16'h0000, 1'b0, 16'h0000},
		'{0, 0, 1, 1000000, 16'h0000, 1'b0, 16'h0000},
		'{0, 0, 65535, 1000, 16'hFFFF, 1'b1, 16'h4000},
		'{0, 0, -65535, -5, 16'hFFFF, 1'b1, 16'hC000},
		'{0, 0, 70000, -65535, 16'hFFFF, 1'b1, 16'h0000},
		'{0, 0, -70000, 65535, 16'hFFFF, 1'b1, 16'h8000},
		'{0, 0, 65536, 65536, 16'hFFFF, 1'b0, 16'h0000},
		'{0, 0, 1, -2, 16'h0001, 1'b1, 16'hC000}
	};

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	logic [bafn_pkg::COORD_W-1:0]   observer_x;
	logic [bafn_pkg::COORD_W-1:0]   observer_y;
	logic [bafn_pkg::COORD_W-1:0]   target_x;
	logic [bafn_pkg::COORD_W-1:0]   target_y;
	logic                           cfg_wr_en;
	logic [bafn_pkg::TOL_W-1:0]     cfg_wr_data;
	logic                           done;
	logic [bafn_pkg::BEARING_W-1:0] bearing;

	logic                           row_typed;
	logic [bafn_pkg::BEARING_W-1:0] row_want;
	logic [bafn_pkg::TOL_W-1:0]     tol_model = '0;
	logic [bafn_pkg::BEARING_W-1:0] bearing_due [$];
	int unsigned                    req_taken = 0;
	int unsigned                    cycle_count = 0;
	int unsigned                    mismatches = 0;

	bearing_angle_full_turn dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.observer_x  (observer_x),
		.observer_y  (observer_y),
		.target_x    (target_x),
		.target_y    (target_y),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.done        (done),
		.bearing     (bearing)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint quadrant_one_angle(longint ax, longint ay);
		longint x;
		longint y;
		longint z;
		longint xs;
		longint ys;
		x = ax <<< bafn_pkg::PRESHIFT;
		y = ay <<< bafn_pkg::PRESHIFT;
		z = 0;
		for (int i = 0; i < N_STAGES && i < bafn_pkg::MAX_STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ARC_TAB[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ARC_TAB[i];
			end
		end
		if (z < 0)
			z = 0;
		if (z > longint'(bafn_pkg::TURN_QUARTER))
			z = longint'(bafn_pkg::TURN_QUARTER);
		return z;
	endfunction

	function automatic logic [bafn_pkg::BEARING_W-1:0] predict_bearing(
			logic [31:0] ox, logic [31:0] oy, logic [31:0] tx, logic [31:0] ty,
			logic [bafn_pkg::TOL_W-1:0] tol);
		longint dx;
		longint dy;
		longint ax;
		longint ay;
		longint a;
		longint turn;
		longint rounded;
		dx = longint'($signed(tx)) - longint'($signed(ox));
		dy = longint'($signed(ty)) - longint'($signed(oy));
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		if (ax <= longint'(tol)) begin
			turn = (dy > 0) ? longint'(bafn_pkg::TURN_QUARTER)
				: longint'(bafn_pkg::TURN_THREE_QUARTER);
		end else if (ay <= longint'(tol)) begin
			turn = (dx > 0) ? longint'(bafn_pkg::TURN_ZERO) : longint'(bafn_pkg::TURN_HALF);
		end else begin
			a = quadrant_one_angle(ax, ay);
			if (dx < 0)
				turn = (dy < 0) ? longint'(bafn_pkg::TURN_HALF) + a
					: longint'(bafn_pkg::TURN_HALF) - a;
			else
				turn = (dy < 0) ? longint'(bafn_pkg::TURN_FULL) - a : a;
		end
		rounded = (turn + (longint'(1) << (31 - bafn_pkg::ANGLE_BITS_DEF)))
			>>> (32 - bafn_pkg::ANGLE_BITS_DEF);
		return rounded[bafn_pkg::BEARING_W-1:0];
	endfunction

	function automatic logic [31:0] near_offset(int unsigned lim);
		return 32'($urandom_range(0, 2 * lim)) - 32'(lim);
	endfunction

	function automatic logic [31:0] edge_coord();
		case ($urandom_range(0, 4))
			0: return C_MIN;
			1: return C_MAX;
			2: return 32'h0;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] scaled_offset();
		logic [31:0] d;
		d = $urandom >> $urandom_range(0, 31);
		return $urandom_range(0, 1) ? -d : d;
	endfunction

	// The result side cannot stall, so every accepted request is due one bearing.
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
		if (arst_n && done) begin
			if (bearing_due.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= 10)
					$display("Unexpected bearing %h with no request outstanding", bearing);
			end else if (bearing !== bearing_due[0]) begin
				mismatches = mismatches + 1;
				if (mismatches <= 10)
					$display("Bearing mismatch: expected %h, got %h", bearing_due[0], bearing);
				void'(bearing_due.pop_front());
			end else begin
				void'(bearing_due.pop_front());
			end
		end
		if (arst_n && start && !busy) begin
			if (row_typed)
				bearing_due.push_back(row_want);
			else
				bearing_due.push_back(predict_bearing(observer_x, observer_y,
					target_x, target_y, tol_model));
			req_taken = req_taken + 1;
		end
		if (arst_n && cfg_wr_en)
			tol_model = cfg_wr_data;
	end

	task automatic send_request(logic [31:0] ox, logic [31:0] oy, logic [31:0] tx,
			logic [31:0] ty, logic typed, logic [bafn_pkg::BEARING_W-1:0] want);
		int unsigned seen;
		seen = req_taken;
		start      <= 1'b1;
		observer_x <= ox;
		observer_y <= oy;
		target_x   <= tx;
		target_y   <= ty;
		row_typed  <= typed;
		row_want   <= want;
		do
			@(negedge clk);
		while (req_taken == seen);
	endtask

	task automatic idle_gap(inout int burst_left);
		int unsigned pick;
		int unsigned gap;
		if (burst_left > 0) begin
			burst_left = burst_left - 1;
			return;
		end
		if ($urandom_range(0, 49) == 0) begin
			burst_left = $urandom_range(20, 60);
			return;
		end
		pick = $urandom_range(0, 99);
		if (pick < 60)
			gap = 0;
		else if (pick < 90)
			gap = $urandom_range(1, 3);
		else if (pick < 98)
			gap = $urandom_range(4, 10);
		else
			gap = $urandom_range(20, 60);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic settle_and_write(logic [bafn_pkg::TOL_W-1:0] tol);
		start <= 1'b0;
		while (bearing_due.size() != 0)
			@(negedge clk);
		repeat (LAT) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= tol;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		logic [31:0]                ox;
		logic [31:0]                oy;
		logic [31:0]                tx;
		logic [31:0]                ty;
		logic [bafn_pkg::TOL_W-1:0] cur_tol;
		logic [bafn_pkg::TOL_W-1:0] phase_tol;
		int                         burst_left;
		int unsigned                lim;

		arst_n      = 1'b0;
		start       <= 1'b0;
		observer_x  <= '0;
		observer_y  <= '0;
		target_x    <= '0;
		target_y    <= '0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		row_typed   <= 1'b0;
		row_want    <= '0;
		cur_tol     = '0;
		burst_left  = 0;

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int r = 0; r < N_DIR; r++) begin
			if (DIR_TAB[r].tol != cur_tol) begin
				settle_and_write(DIR_TAB[r].tol);
				cur_tol = DIR_TAB[r].tol;
			end
			send_request(DIR_TAB[r].ox, DIR_TAB[r].oy, DIR_TAB[r].tx, DIR_TAB[r].ty,
				DIR_TAB[r].typed, DIR_TAB[r].want);
			idle_gap(burst_left);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0:       phase_tol = '0;
				1:       phase_tol = 16'hFFFF;
				2:       phase_tol = 16'($urandom_range(0, 15));
				default: phase_tol = 16'($urandom_range(0, 65535));
			endcase
			settle_and_write(phase_tol);
			lim = 32'(phase_tol) + 32'd2;
			for (int k = 0; k < PHASE_LEN; k++) begin
				ox = $urandom;
				oy = $urandom;
				case ($urandom_range(0, 9))
					3: begin
						tx = ox + near_offset(lim);
						ty = oy + $urandom;
					end
					4: begin
						tx = ox + $urandom;
						ty = oy + near_offset(lim);
					end
					5: begin
						tx = ox + near_offset(300);
						ty = oy + near_offset(300);
					end
					6: begin
						ox = edge_coord();
						oy = edge_coord();
						tx = edge_coord();
						ty = edge_coord();
					end
					7: begin
						tx = scaled_offset();
						ty = $urandom_range(0, 1) ? -tx : tx;
						tx = ox + tx + near_offset(2);
						ty = oy + ty + near_offset(2);
					end
					8: begin
						tx = ox + near_offset(lim);
						ty = oy + near_offset(lim);
					end
					9: begin
						tx = ox + scaled_offset();
						ty = oy + scaled_offset();
					end
					default: begin
						tx = $urandom;
						ty = $urandom;
					end
				endcase
				send_request(ox, oy, tx, ty, 1'b0, '0);
				idle_gap(burst_left);
			end
		end

		start <= 1'b0;
		while (bearing_due.size() != 0)
			@(negedge clk);
		repeat (2 * LAT) @(negedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: sim.f
hdl/bafn_pkg.sv
hdl/bafn_front.sv
hdl/bafn_stage.sv
hdl/bafn_back.sv
hdl/bearing_angle_full_turn.sv
bench/tb_top.sv
